FILE: sv/lbs_pkg.sv
`default_nettype none

package lbs_pkg;

	localparam int ELEMS  = 12;
	localparam int STEP_W = 5;
	localparam logic [STEP_W-1:0] DONE_STEP = 5'd21;

	typedef enum logic {
		FUNC_LOAD = 1'b0,
		FUNC_ADD  = 1'b1
	} lbs_func_t;

	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_X,
		MUL_Y,
		MUL_Z,
		MUL_W
	} lbs_mul_t;

	typedef enum logic [1:0] {
		SUM_HOLD,
		SUM_BIAS,
		SUM_ADD
	} lbs_sum_t;

	typedef enum logic [1:0] {
		BR_NEXT,
		BR_SKIP,
		BR_DONE
	} lbs_br_t;

	typedef enum logic {
		SEQ_IDLE,
		SEQ_RUN
	} lbs_seq_state_t;

	typedef struct packed {
		logic              rd_en;
		logic [3:0]        rd_elem;
		lbs_mul_t          mul_sel;
		lbs_sum_t          sum_op;
		logic              world_en;
		logic              acc_en;
		logic [1:0]        acc_row;
		lbs_br_t           br;
		logic [STEP_W-1:0] target;
	} lbs_uop_t;

	typedef struct packed {
		logic start;
		logic skip;
		logic hold;
	} lbs_seq_in_t;

	typedef struct packed {
		logic     busy;
		logic     done;
		lbs_uop_t uop;
	} lbs_seq_out_t;

	function automatic logic signed [31:0] lbs_sat32(input logic signed [63:0] v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Microprogram. Each row uses nine steps; rows start six steps apart so the
	// next row's reads and offset products run beside the current row's
	// weight product and accumulate.
	function automatic lbs_uop_t lbs_ucode(input logic [STEP_W-1:0] step);
		lbs_uop_t u;
		u = '0;
		u.mul_sel = MUL_NONE;
		u.sum_op  = SUM_HOLD;
		u.br      = BR_NEXT;
		case (step)
			5'd0: begin
				u.rd_en = 1'b1; u.rd_elem = 4'd3;
				u.br = BR_SKIP; u.target = DONE_STEP;
			end
			5'd1: begin
				u.rd_en = 1'b1; u.rd_elem = 4'd0; u.sum_op = SUM_BIAS;
			end
			5'd2: begin
				u.rd_en = 1'b1; u.rd_elem = 4'd1; u.mul_sel = MUL_X;
			end
			5'd3: begin
				u.rd_en = 1'b1; u.rd_elem = 4'd2; u.mul_sel = MUL_Y; u.sum_op = SUM_ADD;
			end
			5'd4: begin
				u.mul_sel = MUL_Z; u.sum_op = SUM_ADD;
			end
			5'd5: begin
				u.sum_op = SUM_ADD;
			end
			5'd6: begin
				u.world_en = 1'b1; u.rd_en = 1'b1; u.rd_elem = 4'd7;
			end
			5'd7: begin
				u.mul_sel = MUL_W; u.rd_en = 1'b1; u.rd_elem = 4'd4; u.sum_op = SUM_BIAS;
			end
			5'd8: begin
				u.acc_en = 1'b1; u.acc_row = 2'd0;
				u.rd_en = 1'b1; u.rd_elem = 4'd5; u.mul_sel = MUL_X;
			end
			5'd9: begin
				u.rd_en = 1'b1; u.rd_elem = 4'd6; u.mul_sel = MUL_Y; u.sum_op = SUM_ADD;
			end
			5'd10: begin
				u.mul_sel = MUL_Z; u.sum_op = SUM_ADD;
			end
			5'd11: begin
				u.sum_op = SUM_ADD;
			end
			5'd12: begin
				u.world_en = 1'b1; u.rd_en = 1'b1; u.rd_elem = 4'd11;
			end
			5'd13: begin
				u.mul_sel = MUL_W; u.rd_en = 1'b1; u.rd_elem = 4'd8; u.sum_op = SUM_BIAS;
			end
			5'd14: begin
				u.acc_en = 1'b1; u.acc_row = 2'd1;
				u.rd_en = 1'b1; u.rd_elem = 4'd9; u.mul_sel = MUL_X;
			end
			5'd15: begin
				u.rd_en = 1'b1; u.rd_elem = 4'd10; u.mul_sel = MUL_Y; u.sum_op = SUM_ADD;
			end
			5'd16: begin
				u.mul_sel = MUL_Z; u.sum_op = SUM_ADD;
			end
			5'd17: begin
				u.sum_op = SUM_ADD;
			end
			5'd18: begin
				u.world_en = 1'b1;
			end
			5'd19: begin
				u.mul_sel = MUL_W;
			end
			5'd20: begin
				u.acc_en = 1'b1; u.acc_row = 2'd2;
			end
			default: begin
				u.br = BR_DONE;
			end
		endcase
		return u;
	endfunction

endpackage

`default_nettype wire

FILE: sv/lbs_if.sv
`default_nettype none

interface lbs_in_if;
	logic               valid;
	logic               ready;
	logic               func;
	logic [4:0]         bone;
	logic [3:0]         elem;
	logic signed [31:0] mat_value;
	logic [15:0]        weight;
	logic signed [31:0] off_x;
	logic signed [31:0] off_y;
	logic signed [31:0] off_z;
	logic               last_bone;

	modport source (
		output valid, func, bone, elem, mat_value, weight, off_x, off_y, off_z, last_bone,
		input  ready
	);
	modport sink (
		input  valid, func, bone, elem, mat_value, weight, off_x, off_y, off_z, last_bone,
		output ready
	);
endinterface

interface lbs_out_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic signed [31:0] pos_z;

	modport source (
		output valid, pos_x, pos_y, pos_z,
		input  ready
	);
	modport sink (
		input  valid, pos_x, pos_y, pos_z,
		output ready
	);
endinterface

`default_nettype wire

FILE: sv/lbs_bone_mem.sv
`default_nettype none

module lbs_bone_mem #(
	parameter int DEPTH = 384,
	parameter int AW    = 9
) (
	input  wire logic                 clk,
	input  wire logic                 wr_en,
	input  wire logic [AW-1:0]        wr_addr,
	input  wire logic signed [31:0]   wr_data,
	input  wire logic                 rd_en,
	input  wire logic [AW-1:0]        rd_addr,
	output logic signed [31:0]        rd_data
);

	logic signed [31:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem_q[rd_addr];
		end
	end

endmodule

`default_nettype wire

FILE: sv/lbs_sequencer.sv
`default_nettype none

module lbs_sequencer (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire lbs_pkg::lbs_seq_in_t  ctl,
	output lbs_pkg::lbs_seq_out_t      stat
);

	lbs_pkg::lbs_seq_state_t          state_q, state_d;
	logic [lbs_pkg::STEP_W-1:0]       step_q, step_d;
	lbs_pkg::lbs_uop_t                word;

	assign word = lbs_pkg::lbs_ucode(step_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= lbs_pkg::SEQ_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= step_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		step_d    = step_q;
		stat.busy = 1'b0;
		stat.done = 1'b0;
		stat.uop  = '0;
		case (state_q)
			lbs_pkg::SEQ_IDLE: begin
				if (ctl.start) begin
					state_d = lbs_pkg::SEQ_RUN;
					step_d  = '0;
				end
			end
			lbs_pkg::SEQ_RUN: begin
				stat.busy = 1'b1;
				stat.uop  = word;
				case (word.br)
					lbs_pkg::BR_NEXT: begin
						step_d = step_q + 1'b1;
					end
					lbs_pkg::BR_SKIP: begin
						step_d = ctl.skip ? word.target : step_q + 1'b1;
					end
					lbs_pkg::BR_DONE: begin
						if (!ctl.hold) begin
							stat.done = 1'b1;
							state_d   = lbs_pkg::SEQ_IDLE;
						end
					end
					default: begin
						state_d = lbs_pkg::SEQ_IDLE;
					end
				endcase
			end
			default: begin
				state_d = lbs_pkg::SEQ_IDLE;
			end
		endcase
	end

endmodule

`default_nettype wire

FILE: sv/lbs_datapath.sv
`default_nettype none

module lbs_datapath (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire lbs_pkg::lbs_uop_t   uop,
	input  wire logic                clr,
	input  wire logic signed [31:0]  rdata,
	input  wire logic signed [31:0]  off_x,
	input  wire logic signed [31:0]  off_y,
	input  wire logic signed [31:0]  off_z,
	input  wire logic [15:0]         weight,
	output logic signed [31:0]       acc_x,
	output logic signed [31:0]       acc_y,
	output logic signed [31:0]       acc_z
);

	logic signed [63:0] prod_q;
	logic signed [49:0] sum_q;
	logic signed [31:0] world_q;
	logic signed [31:0] acc_q [3];

	logic signed [31:0] mul_a;
	logic signed [31:0] mul_b;
	logic signed [63:0] mul_p;
	logic signed [31:0] part;
	logic signed [31:0] acc_new;

	always_comb begin
		mul_a = rdata;
		mul_b = off_x;
		case (uop.mul_sel)
			lbs_pkg::MUL_Y: mul_b = off_y;
			lbs_pkg::MUL_Z: mul_b = off_z;
			lbs_pkg::MUL_W: begin
				mul_a = world_q;
				mul_b = {16'd0, weight};
			end
			default: mul_b = off_x;
		endcase
	end

	assign mul_p   = mul_a * mul_b;
	// Weighted row value: floor(world * weight / 2^15), saturated.
	assign part    = lbs_pkg::lbs_sat32({{15{prod_q[63]}}, prod_q[63:15]});
	assign acc_new = lbs_pkg::lbs_sat32(64'(acc_q[uop.acc_row]) + 64'(part));

	always_ff @(posedge clk) begin
		if (uop.mul_sel != lbs_pkg::MUL_NONE) begin
			prod_q <= mul_p;
		end
		case (uop.sum_op)
			lbs_pkg::SUM_BIAS: sum_q <= {{18{rdata[31]}}, rdata};
			lbs_pkg::SUM_ADD:  sum_q <= sum_q + {{2{prod_q[63]}}, prod_q[63:16]};
			default:           sum_q <= sum_q;
		endcase
		if (uop.world_en) begin
			world_q <= lbs_pkg::lbs_sat32(64'(sum_q));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
		end else if (clr) begin
			acc_q[0] <= '0;
			acc_q[1] <= '0;
			acc_q[2] <= '0;
		end else if (uop.acc_en) begin
			acc_q[uop.acc_row] <= acc_new;
		end
	end

	assign acc_x = acc_q[0];
	assign acc_y = acc_q[1];
	assign acc_z = acc_q[2];

endmodule

`default_nettype wire

FILE: sv/linear_blend_skinning.sv
// Linear blend skinning with a per-bone 3x4 affine matrix store.
//
// Input channel req carries two kinds of beat. A load beat (func = load)
// writes one Q16.16 matrix element of one bone; it is taken while the block is idle and
// produces nothing. A contribution beat (func = add) transforms the offset by
// the bone's matrix, scales it by the Q1.15 weight and adds it into the
// saturating x/y/z accumulator. Its last_bone flag closes the vertex: the
// accumulated position goes out as one beat on rsp and the accumulator clears.
//
// A contribution occupies the block from acceptance through 21 steps of the
// microprogram, all around one shared 32x32 multiplier and the registered
// read port of the matrix memory, plus the closing step. A beat with a zero
// weight or an out-of-range bone skips the program from its first step to the
// closing step; a last beat's result goes out on rsp from the output register.
//
// Reset clears the sequencer, the accumulator and the output valid flag; the
// matrix memory is not cleared and must be loaded before use. A stalled rsp
// keeps its beat in the output register; a following last beat waits at its
// closing step until that register frees.
`default_nettype none

module linear_blend_skinning #(
	parameter int MAX_BONES = 32
) (
	input  wire logic     clk,
	input  wire logic     arst_n,
	lbs_in_if.sink        req,
	lbs_out_if.source     rsp
);

	localparam int DEPTH = MAX_BONES * lbs_pkg::ELEMS;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	// Item registers captured when a contribution is accepted.
	logic [4:0]         bone_q;
	logic [15:0]        weight_q;
	logic signed [31:0] off_x_q;
	logic signed [31:0] off_y_q;
	logic signed [31:0] off_z_q;
	logic               last_q;
	logic               bone_ok_q;

	// Output register.
	logic               rsp_valid_q;
	logic signed [31:0] pos_x_q;
	logic signed [31:0] pos_y_q;
	logic signed [31:0] pos_z_q;

	logic                  accept;
	logic                  is_add;
	logic                  bone_ok;
	logic                  wr_en;
	logic [12:0]           wr_full;
	logic [12:0]           rd_full;
	logic signed [31:0]    rdata;
	logic                  emit;
	logic signed [31:0]    acc_x;
	logic signed [31:0]    acc_y;
	logic signed [31:0]    acc_z;
	lbs_pkg::lbs_seq_in_t  seq_ctl;
	lbs_pkg::lbs_seq_out_t seq_stat;

	assign req.ready = !seq_stat.busy;
	assign accept    = req.valid && req.ready;
	assign is_add    = (lbs_pkg::lbs_func_t'(req.func) == lbs_pkg::FUNC_ADD);
	assign bone_ok   = (int'(req.bone) < MAX_BONES);

	// Loads go straight into the memory; an element index past the last
	// column of row two, or a bone past the store, is dropped.
	assign wr_en   = accept && !is_add && bone_ok && (int'(req.elem) < lbs_pkg::ELEMS);
	assign wr_full = 13'(req.bone) * 13'(lbs_pkg::ELEMS) + 13'(req.elem);
	assign rd_full = 13'(bone_q) * 13'(lbs_pkg::ELEMS) + 13'(seq_stat.uop.rd_elem);

	always_ff @(posedge clk) begin
		if (accept && is_add) begin
			bone_q    <= req.bone;
			weight_q  <= req.weight;
			off_x_q   <= req.off_x;
			off_y_q   <= req.off_y;
			off_z_q   <= req.off_z;
			last_q    <= req.last_bone;
			bone_ok_q <= bone_ok;
		end
	end

	lbs_bone_mem #(
		.DEPTH (DEPTH),
		.AW    (AW)
	) u_mem (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_full[AW-1:0]),
		.wr_data (req.mat_value),
		.rd_en   (seq_stat.uop.rd_en && bone_ok_q),
		.rd_addr (rd_full[AW-1:0]),
		.rd_data (rdata)
	);

	// The closing step of a last beat holds while the output register still
	// has a beat the receiver has not taken.
	assign seq_ctl.start = accept && is_add;
	assign seq_ctl.skip  = (weight_q == 16'd0) || !bone_ok_q;
	assign seq_ctl.hold  = last_q && rsp_valid_q && !rsp.ready;

	lbs_sequencer u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (seq_ctl),
		.stat   (seq_stat)
	);

	assign emit = seq_stat.done && last_q;

	lbs_datapath u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.uop    (seq_stat.uop),
		.clr    (emit),
		.rdata  (rdata),
		.off_x  (off_x_q),
		.off_y  (off_y_q),
		.off_z  (off_z_q),
		.weight (weight_q),
		.acc_x  (acc_x),
		.acc_y  (acc_y),
		.acc_z  (acc_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (emit) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pos_x_q <= acc_x;
			pos_y_q <= acc_y;
			pos_z_q <= acc_z;
		end
	end

	assign rsp.valid = rsp_valid_q;
	assign rsp.pos_x = pos_x_q;
	assign rsp.pos_y = pos_y_q;
	assign rsp.pos_z = pos_z_q;

	// A closed vertex leaves a cleared accumulator behind.
	a_clear_after_emit: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> (acc_x == 32'sd0 && acc_y == 32'sd0 && acc_z == 32'sd0))
		else $error("accumulator not cleared after a vertex was emitted");

	// Matrix loads only happen while no contribution is in flight.
	a_load_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> !seq_stat.busy)
		else $error("matrix load while the sequencer is running");

	// An emit never overwrites a beat that is still waiting on rsp.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		emit |-> (!rsp_valid_q || rsp.ready))
		else $error("result register overwritten before it was taken");

	// An accepted contribution starts the microprogram in the next cycle.
	a_start: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && is_add) |=> seq_stat.busy)
		else $error("contribution accepted but sequencer not started");

endmodule

`default_nettype wire

FILE: test/tb_linear_blend_skinning.sv
`default_nettype none

// Self-checking bench for linear_blend_skinning.
//
// Stimulus runs through the req channel in two parts. A short directed table
// loads an identity-like pose into bone 0 and then probes the corners of the
// arithmetic; the rows whose result is obvious carry their expected position.
// A random part follows. It builds whole bone matrices, sprinkles stray loads
// among them, and sends vertices made of one to four weighted contributions.
// Every accepted beat also goes through a predictor that keeps its own copy of
// the bone store and the accumulator. Every vertex that closes pushes an
// expected position, and each beat seen on rsp is checked against the oldest
// one.
module tb_linear_blend_skinning;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int ELEMS       = lbs_pkg::ELEMS;
	localparam int NUM_BONES   = 32;
	localparam int RAND_BEATS  = 900;
	localparam int HOLD_CYCLES = 400;
	// The longest quiet stretch in a correct run is the receiver hold-off plus
	// one contribution and one sender gap; the limit allows several times that.
	localparam int IDLE_LIMIT  = 4000;
	localparam int DRAIN_WAIT  = 60;

	// One req beat as the bench sees it.
	typedef struct {
		lbs_pkg::lbs_func_t func;
		logic [4:0]         bone;
		logic [3:0]         elem;
		logic signed [31:0] mat_value;
		logic [15:0]        weight;
		logic signed [31:0] off_x;
		logic signed [31:0] off_y;
		logic signed [31:0] off_z;
		logic               last_bone;
	} beat_t;

	// A beat plus, for table rows whose outcome is plain, the position it must
	// produce.
	typedef struct {
		beat_t              b;
		bit                 typed;
		logic signed [31:0] want [3];
	} row_t;

	typedef struct {
		logic signed [31:0] xyz [3];
	} vtx_t;

	logic clk;
	logic arst_n;

	lbs_in_if  req_if ();
	lbs_out_if rsp_if ();

	linear_blend_skinning #(
		.MAX_BONES(NUM_BONES)
	) dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	always #5 clk = ~clk;

	// ------------------------------------------------------------------
	// Predictor state: the pose store, the running position and the queue
	// of positions still owed by the block.
	// ------------------------------------------------------------------
	logic signed [31:0] pose_mem [NUM_BONES][ELEMS];
	logic signed [31:0] acc_pos [3];
	vtx_t               vtx_q [$];

	// Side information travelling with the beat on req, updated together with
	// the payload so that the monitor sees the tag of the beat being taken.
	bit                 drv_typed;
	logic signed [31:0] drv_want [3];

	// Stimulus-side bookkeeping. A contribution with a nonzero weight may only
	// name a bone whose twelve elements have all been written.
	bit [ELEMS-1:0] elem_set [NUM_BONES];
	bit             listed [NUM_BONES];
	int             full_bones [$];

	int  n_sent;
	int  n_load;
	int  n_add;
	int  n_zero_wt;
	int  n_vtx;
	int  n_err;
	int  idle_cnt;
	int  burst_left;
	bit  hold_done;

	function automatic logic signed [31:0] clamp_q32(input longint v);
		logic signed [31:0] r;
		if (v > 64'sd2147483647) begin
			r = 32'sh7fffffff;
		end else if (v < -64'sd2147483648) begin
			r = 32'sh80000000;
		end else begin
			r = v[31:0];
		end
		return r;
	endfunction

	// Apply one accepted beat to the predictor. A load writes the pose store,
	// a contribution blends into the running position, and a last mark on a
	// contribution closes the vertex.
	task automatic skin_beat(input beat_t b, input bit typed, input vtx_t want);
		logic signed [31:0] offv [3];
		logic signed [31:0] world;
		logic signed [31:0] part;
		longint             sum;
		vtx_t               v;
		int                 r;
		int                 c;
		offv[0] = b.off_x;
		offv[1] = b.off_y;
		offv[2] = b.off_z;
		if (b.func == lbs_pkg::FUNC_LOAD) begin
			n_load++;
			// Element codes twelve to fifteen are dropped by the block.
			if (b.elem < ELEMS && b.bone < NUM_BONES) begin
				pose_mem[b.bone][b.elem] = b.mat_value;
			end
		end else begin
			n_add++;
			if (b.weight == 0) begin
				n_zero_wt++;
			end else if (b.bone < NUM_BONES) begin
				for (r = 0; r < 3; r++) begin
					// Bias first, then each column product floored back to Q16.16.
					sum = longint'(pose_mem[b.bone][r*4+3]);
					for (c = 0; c < 3; c++) begin
						sum += (longint'(pose_mem[b.bone][r*4+c]) * longint'(offv[c])) >>> 16;
					end
					world = clamp_q32(sum);
					part = clamp_q32((longint'(world) * longint'({1'b0, b.weight})) >>> 15);
					acc_pos[r] = clamp_q32(longint'(acc_pos[r]) + longint'(part));
				end
			end
			if (b.last_bone) begin
				// A table row with a plain answer is held to that answer; every
				// other vertex is held to the predictor.
				if (typed) begin
					v.xyz = want.xyz;
				end else begin
					v.xyz = acc_pos;
				end
				vtx_q.push_back(v);
				acc_pos = '{default: '0};
			end
		end
	endtask

	// ------------------------------------------------------------------
	// Beat builders. Fields that the operation does not use are filled with
	// random bits so that they toggle too.
	// ------------------------------------------------------------------
	function automatic row_t ld(input int bn, input int en, input logic signed [31:0] val,
			input bit lst);
		row_t r;
		r.b.func      = lbs_pkg::FUNC_LOAD;
		r.b.bone      = bn[4:0];
		r.b.elem      = en[3:0];
		r.b.mat_value = val;
		r.b.weight    = 16'($urandom);
		r.b.off_x     = $urandom;
		r.b.off_y     = $urandom;
		r.b.off_z     = $urandom;
		r.b.last_bone = lst;
		r.typed       = 1'b0;
		r.want        = '{default: '0};
		return r;
	endfunction

	function automatic row_t ad(input int bn, input int wt, input logic signed [31:0] ox,
			input logic signed [31:0] oy, input logic signed [31:0] oz, input bit lst);
		row_t r;
		r.b.func      = lbs_pkg::FUNC_ADD;
		r.b.bone      = bn[4:0];
		r.b.elem      = 4'($urandom);
		r.b.mat_value = $urandom;
		r.b.weight    = wt[15:0];
		r.b.off_x     = ox;
		r.b.off_y     = oy;
		r.b.off_z     = oz;
		r.b.last_bone = lst;
		r.typed       = 1'b0;
		r.want        = '{default: '0};
		return r;
	endfunction

	function automatic row_t with_pos(input row_t r, input logic signed [31:0] x,
			input logic signed [31:0] y, input logic signed [31:0] z);
		row_t o;
		o       = r;
		o.typed = 1'b1;
		o.want  = '{x, y, z};
		return o;
	endfunction

	// Q16.16 word within +/- 2^sc LSBs, or with a chance of wild percent one of the
	// full-range corners or a fully random word.
	function automatic logic signed [31:0] rnd_q(input int sc, input int wild);
		logic signed [31:0] q;
		if ($urandom_range(0, 99) < wild) begin
			case ($urandom_range(0, 4))
				0: q = 32'sh7fffffff;
				1: q = 32'sh80000000;
				2: q = '0;
				3: q = -32'sd1;
				default: q = $urandom;
			endcase
		end else begin
			q = $signed($urandom_range(0, (1 << (sc + 1)) - 1)) - (1 << sc);
		end
		return q;
	endfunction

	// Mostly ordinary fractions, with zero, exactly one, the smallest step and
	// weights beyond one mixed in.
	function automatic int rnd_weight();
		int w;
		case ($urandom_range(0, 19))
			0: w = 0;
			1: w = 32768;
			2: w = $urandom_range(32769, 65535);
			3: w = 1;
			default: w = $urandom_range(1, 32767);
		endcase
		return w;
	endfunction

	// ------------------------------------------------------------------
	// Sender. Beats go out in bursts; between bursts valid drops for a random
	// number of cycles. Inside a burst the next beat replaces the payload in
	// the same step as the accept, so valid never glitches.
	// ------------------------------------------------------------------
	task automatic send(input row_t r);
		req_if.valid     <= 1'b1;
		req_if.func      <= r.b.func;
		req_if.bone      <= r.b.bone;
		req_if.elem      <= r.b.elem;
		req_if.mat_value <= r.b.mat_value;
		req_if.weight    <= r.b.weight;
		req_if.off_x     <= r.b.off_x;
		req_if.off_y     <= r.b.off_y;
		req_if.off_z     <= r.b.off_z;
		req_if.last_bone <= r.b.last_bone;
		drv_typed        <= r.typed;
		drv_want         <= r.want;
		if (r.b.func == lbs_pkg::FUNC_LOAD && r.b.elem < ELEMS) begin
			elem_set[r.b.bone][r.b.elem] = 1'b1;
			if (!listed[r.b.bone] && (&elem_set[r.b.bone])) begin
				listed[r.b.bone] = 1'b1;
				full_bones.push_back(r.b.bone);
			end
		end
		do @(posedge clk); while (!req_if.ready);
		n_sent++;
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			req_if.valid <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
			// Now and then a long burst leaves the block running with no gaps.
			burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(0, 8);
		end
	endtask

	// Write all twelve elements of one bone, in a rotated order. The linear
	// part stays near unit scale and the bias within a few hundred units, so
	// that most vertices come out unsaturated.
	task automatic load_bone(input int bn);
		int s;
		int k;
		int e;
		s = $urandom_range(0, 11);
		for (k = 0; k < ELEMS; k++) begin
			e = (k * 5 + s) % ELEMS;
			send(ld(bn, e, (e % 4 == 3) ? rnd_q(24, 3) : rnd_q(17, 3),
				$urandom_range(0, 7) == 0));
		end
	endtask

	// A stray load: any bone, any element code including the dropped ones,
	// and a value that is often a corner.
	task automatic stray_load();
		send(ld($urandom_range(0, NUM_BONES - 1), $urandom_range(0, 15), rnd_q(20, 50),
			$urandom_range(0, 1) == 1));
	endtask

	// One vertex of one to four contributions, the last one marked. A stray
	// load may sit between contributions; it must not disturb the running sum.
	task automatic send_vertex();
		int n;
		int i;
		int wt;
		int bn;
		n = $urandom_range(1, 4);
		for (i = 0; i < n; i++) begin
			if ($urandom_range(0, 9) == 0) begin
				stray_load();
			end
			wt = rnd_weight();
			// A zero weight skips the matrix program, so any bone will do for it.
			bn = (wt == 0) ? $urandom_range(0, NUM_BONES - 1)
				: full_bones[$urandom_range(0, full_bones.size() - 1)];
			send(ad(bn, wt, rnd_q(22, 5), rnd_q(22, 5), rnd_q(22, 5), i == n - 1));
		end
	endtask

	// ------------------------------------------------------------------
	// Monitor on req: every accepted beat drives the predictor.
	// ------------------------------------------------------------------
	always @(posedge clk) begin : req_monitor
		beat_t b;
		vtx_t  w;
		if (arst_n && req_if.valid && req_if.ready) begin
			b.func      = lbs_pkg::lbs_func_t'(req_if.func);
			b.bone      = req_if.bone;
			b.elem      = req_if.elem;
			b.mat_value = req_if.mat_value;
			b.weight    = req_if.weight;
			b.off_x     = req_if.off_x;
			b.off_y     = req_if.off_y;
			b.off_z     = req_if.off_z;
			b.last_bone = req_if.last_bone;
			w.xyz       = drv_want;
			skin_beat(b, drv_typed, w);
		end
	end

	// ------------------------------------------------------------------
	// Checker on rsp: each position is compared axis by axis with the oldest
	// one still owed.
	// ------------------------------------------------------------------
	function automatic void check_axis(input string axis, input logic signed [31:0] exp_v,
			input logic signed [31:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: vertex %0d pos_%s mismatch: expected %h, got %h",
				$time, n_vtx, axis, exp_v, got_v);
			n_err++;
		end
	endfunction

	always @(posedge clk) begin : rsp_checker
		vtx_t e;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			if (vtx_q.size() == 0) begin
				$display("%0t: unexpected position beat: expected none, got %h %h %h",
					$time, rsp_if.pos_x, rsp_if.pos_y, rsp_if.pos_z);
				n_err++;
			end else begin
				e = vtx_q.pop_front();
				check_axis("x", e.xyz[0], rsp_if.pos_x);
				check_axis("y", e.xyz[1], rsp_if.pos_y);
				check_axis("z", e.xyz[2], rsp_if.pos_z);
			end
			n_vtx++;
		end
	end

	// ------------------------------------------------------------------
	// Receiver. It changes its stall pattern after each run of random length, and once,
	// after some vertices are through, it holds ready low for a long stretch
	// while the sender keeps offering beats. The output register fills, the
	// next last beat parks at its closing step, and req has to back up.
	// ------------------------------------------------------------------
	initial begin : receiver
		int mode;
		int len;
		rsp_if.ready = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (!hold_done && n_vtx >= 20) begin
				hold_done = 1'b1;
				rsp_if.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
			end else begin
				mode = $urandom_range(0, 3);
				len = $urandom_range(10, 80);
				repeat (len) begin
					case (mode)
						0: rsp_if.ready <= 1'b1;
						1: rsp_if.ready <= ($urandom_range(0, 1) == 1);
						2: rsp_if.ready <= ($urandom_range(0, 3) == 0);
						default: rsp_if.ready <= ~rsp_if.ready;
					endcase
					@(posedge clk);
				end
			end
		end
	end

	// Watchdog: any cycle in which neither channel moves a beat counts toward
	// the limit.
	always @(posedge clk) begin
		if ((req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
			idle_cnt <= 0;
		end else begin
			idle_cnt <= idle_cnt + 1;
		end
		if (idle_cnt >= IDLE_LIMIT) begin
			$display("%0t: no beat accepted for %0d cycles", $time, IDLE_LIMIT);
			$display("** linear_blend_skinning: FAILED **");
			$finish;
		end
	end

	// ------------------------------------------------------------------
	// Directed table. Bone 0 gets the identity with a bias of (+1, -1, 0).
	// The rows with a position given are plain to read: the reset state, an
	// integer offset through the identity, and saturation on every axis.
	// ------------------------------------------------------------------
	row_t dir_tab [22];

	initial begin : stimulus
		int i;
		clk        = 1'b0;
		arst_n     = 1'b0;
		hold_done  = 1'b0;
		n_sent     = 0;
		n_load     = 0;
		n_add      = 0;
		n_zero_wt  = 0;
		n_vtx      = 0;
		n_err      = 0;
		idle_cnt   = 0;
		burst_left = 0;
		acc_pos    = '{default: '0};
		drv_typed  = 1'b0;
		drv_want   = '{default: '0};
		for (i = 0; i < NUM_BONES; i++) begin
			elem_set[i] = '0;
			listed[i]   = 1'b0;
			pose_mem[i] = '{default: '0};
		end
		req_if.valid     = 1'b0;
		req_if.func      = lbs_pkg::FUNC_LOAD;
		req_if.bone      = '0;
		req_if.elem      = '0;
		req_if.mat_value = '0;
		req_if.weight    = '0;
		req_if.off_x     = '0;
		req_if.off_y     = '0;
		req_if.off_z     = '0;
		req_if.last_bone = 1'b0;

		dir_tab = '{
			// Straight out of reset a zero-weight last beat skips the matrix program and
			// must still emit the cleared accumulator.
			with_pos(ad(31, 0, $urandom, $urandom, $urandom, 1'b1), 0, 0, 0),
			ld(0, 0, 32'sh00010000, 1'b0),
			ld(0, 1, 32'sh00000000, 1'b0),
			ld(0, 2, 32'sh00000000, 1'b0),
			ld(0, 3, 32'sh00010000, 1'b0),
			ld(0, 4, 32'sh00000000, 1'b0),
			ld(0, 5, 32'sh00010000, 1'b0),
			ld(0, 6, 32'sh00000000, 1'b0),
			ld(0, 7, 32'shffff0000, 1'b0),
			ld(0, 8, 32'sh00000000, 1'b0),
			ld(0, 9, 32'sh00000000, 1'b0),
			ld(0, 10, 32'sh00010000, 1'b0),
			// A last mark on a load yields nothing.
			ld(0, 11, 32'sh00000000, 1'b1),
			// Element code fifteen is dropped; bone 0 must stay intact.
			ld(0, 15, 32'sh80000000, 1'b0),
			with_pos(ad(0, 32768, 32'sh00010000, 32'sh00020000, 32'sh00030000, 1'b1),
				32'sh00020000, 32'sh00010000, 32'sh00030000),
			// Full-scale offsets push every row into saturation.
			with_pos(ad(0, 32768, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1),
				32'sh7fffffff, 32'sh80000000, 32'sh7fffffff),
			// Two of them back to back saturate the accumulator as well.
			ad(0, 32768, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b0),
			with_pos(ad(0, 32768, 32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 1'b1),
				32'sh7fffffff, 32'sh80000000, 32'sh7fffffff),
			// The largest weight, just under two.
			ad(0, 65535, 32'sh12345678, -32'sh0abcdef0, 32'sh00fedcba, 1'b1),
			// A skipped zero weight, the smallest weight and a half weight
			// blended into one vertex.
			ad(0, 0, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff, 1'b0),
			ad(0, 1, 32'sh40000000, 32'sh40000000, 32'sh40000000, 1'b0),
			ad(0, 16384, 32'sh00008000, 32'sh00008000, -32'sh00008000, 1'b1)
		};

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_tab[k]) begin
			send(dir_tab[k]);
		end

		// Random part: whole bone matrices, stray loads and vertices. The first
		// rounds fill a few bones so that vertices have something to use.
		while (n_sent < RAND_BEATS) begin
			i = $urandom_range(0, 99);
			if (full_bones.size() < 3 || i < 12) begin
				load_bone($urandom_range(0, NUM_BONES - 1));
			end else if (i < 22) begin
				stray_load();
			end else begin
				send_vertex();
			end
		end
		req_if.valid <= 1'b0;

		// Let every owed position drain, then give the block time to show any
		// stray beat.
		while (vtx_q.size() != 0) @(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);

		$display("Covered %0d beats: %0d matrix loads, %0d contributions (%0d zero weight).",
			n_sent, n_load, n_add, n_zero_wt);
		$display("Checked %0d vertices across %0d loaded bones, hold-off %0s; %0d mismatches.",
			n_vtx, full_bones.size(), hold_done ? "done" : "not reached", n_err);
		if (n_err == 0) begin
			$display("** linear_blend_skinning: PASSED **");
		end else begin
			$display("** linear_blend_skinning: FAILED **");
		end
		$finish;
	end

endmodule

`default_nettype wire
